FILE: rtl/frame_header_deframer_top_defines.svh
// assertion macros for the frame header deframer checker
`ifndef FRAME_HEADER_DEFRAMER_TOP_DEFINES_SVH
`define FRAME_HEADER_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define FHD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fhd_pkg.sv
// shared types, constants and helpers for the frame header deframer
package fhd_pkg;

    localparam int SEQ_BITS = 64;
    localparam logic [SEQ_BITS-1:0] SEQ_TOP = {SEQ_BITS{1'b1}};

    localparam int HDR_LEN = 20;
    localparam int HDR_IDX_W = 5;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WIRE_VERSION  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_LOWEST   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_HIGHEST  = CFG_IDX_W'(3);

    localparam logic [15:0] WIRE_VERSION_RST  = 16'd1;
    localparam logic [31:0] PAYLOAD_LIMIT_RST = 32'd1048576;
    localparam logic [15:0] TYPE_LOWEST_RST   = 16'd0;
    localparam logic [15:0] TYPE_HIGHEST_RST  = 16'hFFFF;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_TYPE      = 3'd2;
    localparam logic [2:0] ERR_SEQUENCE  = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;
    localparam logic [2:0] ERR_EXHAUSTED = 3'd5;

    localparam logic [7:0] MAGIC_0 = 8'h54;
    localparam logic [7:0] MAGIC_1 = 8'h50;
    localparam logic [7:0] MAGIC_2 = 8'h32;
    localparam logic [7:0] MAGIC_3 = 8'h50;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;
    localparam int QUEUE_CW = 2;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [15:0] frame_type;
        logic [63:0] frame_sequence;
        logic [31:0] frame_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [2:0]  error_code;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = MAGIC_0;
            2'd1:    b = MAGIC_1;
            2'd2:    b = MAGIC_2;
            default: b = MAGIC_3;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/fhd_front.sv
// front end: byte intake, header assembly, header checks and frame tracking
module fhd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stream_valid,
    input  logic [7:0]                      stream_byte,
    output logic                            stream_stall,
    input  logic                            cfg_write,
    input  logic [fhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fhd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  fhd_pkg::queue_status_t          q_status,
    output logic                            push,
    output fhd_pkg::item_t                  push_word
);

    logic [15:0] wire_version_reg;
    logic [31:0] payload_limit_reg;
    logic [15:0] type_lowest_reg;
    logic [15:0] type_highest_reg;

    logic [fhd_pkg::HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic        magic_good_reg, magic_good_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] type_reg, type_next;
    logic [63:0] seq_reg, seq_next;
    logic [31:0] len_reg, len_next;
    logic [fhd_pkg::SEQ_BITS-1:0] exp_reg, exp_next;
    logic [31:0] left_reg, left_next;
    logic        in_payload_reg, in_payload_next;
    logic        err_reg, err_next;

    logic        accept;
    logic [31:0] left_dec;
    logic        seq_exhausted;
    logic [1:0]  kind_v;
    logic [7:0]  byte_v;
    logic        last_v;
    logic [2:0]  code_v;

    assign stream_stall  = q_status.full;
    assign accept        = stream_valid && !q_status.full;
    assign left_dec      = left_reg - 32'd1;
    assign seq_exhausted = (exp_reg == fhd_pkg::SEQ_TOP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_version_reg  <= fhd_pkg::WIRE_VERSION_RST;
            payload_limit_reg <= fhd_pkg::PAYLOAD_LIMIT_RST;
            type_lowest_reg   <= fhd_pkg::TYPE_LOWEST_RST;
            type_highest_reg  <= fhd_pkg::TYPE_HIGHEST_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fhd_pkg::REG_WIRE_VERSION:  wire_version_reg  <= cfg_data[15:0];
                fhd_pkg::REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data[31:0];
                fhd_pkg::REG_TYPE_LOWEST:   type_lowest_reg   <= cfg_data[15:0];
                fhd_pkg::REG_TYPE_HIGHEST:  type_highest_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg    <= '0;
            magic_good_reg <= 1'b1;
            version_reg    <= '0;
            type_reg       <= '0;
            seq_reg        <= '0;
            len_reg        <= '0;
            exp_reg        <= '0;
            left_reg       <= '0;
            in_payload_reg <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            hdr_idx_reg    <= hdr_idx_next;
            magic_good_reg <= magic_good_next;
            version_reg    <= version_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            len_reg        <= len_next;
            exp_reg        <= exp_next;
            left_reg       <= left_next;
            in_payload_reg <= in_payload_next;
            err_reg        <= err_next;
        end
    end

    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        magic_good_next = magic_good_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        exp_next        = exp_reg;
        left_next       = left_reg;
        in_payload_next = in_payload_reg;
        err_next        = err_reg;
        push            = 1'b0;
        kind_v          = fhd_pkg::KIND_HEADER;
        byte_v          = 8'd0;
        last_v          = 1'b0;
        code_v          = fhd_pkg::ERR_MAGIC;

        if (accept && !err_reg)
        begin
            if (in_payload_reg)
            begin
                left_next = left_dec;
                push      = 1'b1;
                if (left_dec != 32'd0)
                begin
                    kind_v = fhd_pkg::KIND_PAYLOAD;
                    byte_v = stream_byte;
                end
                else if (seq_exhausted)
                begin
                    kind_v          = fhd_pkg::KIND_ERROR;
                    code_v          = fhd_pkg::ERR_EXHAUSTED;
                    err_next        = 1'b1;
                    in_payload_next = 1'b0;
                end
                else
                begin
                    kind_v          = fhd_pkg::KIND_PAYLOAD;
                    byte_v          = stream_byte;
                    last_v          = 1'b1;
                    exp_next        = exp_reg + 1'b1;
                    hdr_idx_next    = '0;
                    magic_good_next = 1'b1;
                    in_payload_next = 1'b0;
                end
            end
            else
            begin
                // magic bytes at positions zero to three
                if (hdr_idx_reg < fhd_pkg::HDR_IDX_W'(4) &&
                    stream_byte != fhd_pkg::magic_byte(hdr_idx_reg[1:0]))
                begin
                    magic_good_next = 1'b0;
                end
                if (hdr_idx_reg == fhd_pkg::HDR_IDX_W'(4) ||
                    hdr_idx_reg == fhd_pkg::HDR_IDX_W'(5))
                begin
                    version_next = {version_reg[7:0], stream_byte};
                end
                else if (hdr_idx_reg == fhd_pkg::HDR_IDX_W'(6) ||
                         hdr_idx_reg == fhd_pkg::HDR_IDX_W'(7))
                begin
                    type_next = {type_reg[7:0], stream_byte};
                end
                else if (hdr_idx_reg >= fhd_pkg::HDR_IDX_W'(8) &&
                         hdr_idx_reg <= fhd_pkg::HDR_IDX_W'(15))
                begin
                    seq_next = {seq_reg[55:0], stream_byte};
                end
                else if (hdr_idx_reg >= fhd_pkg::HDR_IDX_W'(16) &&
                         hdr_idx_reg <= fhd_pkg::HDR_LAST)
                begin
                    len_next = {len_reg[23:0], stream_byte};
                end

                if (hdr_idx_reg != fhd_pkg::HDR_LAST)
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                end
                else
                begin
                    push = 1'b1;
                    if (!magic_good_next)
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_MAGIC;
                    end
                    else if (version_next != wire_version_reg)
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_VERSION;
                    end
                    else if (type_next < type_lowest_reg || type_next > type_highest_reg)
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_TYPE;
                    end
                    else if (seq_next != 64'(exp_reg))
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_SEQUENCE;
                    end
                    else if (len_next > payload_limit_reg)
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_LENGTH;
                    end
                    else if (len_next != 32'd0)
                    begin
                        kind_v          = fhd_pkg::KIND_HEADER;
                        left_next       = len_next;
                        in_payload_next = 1'b1;
                    end
                    else if (seq_exhausted)
                    begin
                        kind_v = fhd_pkg::KIND_ERROR;
                        code_v = fhd_pkg::ERR_EXHAUSTED;
                    end
                    else
                    begin
                        // empty payload closes the frame on the header word
                        kind_v          = fhd_pkg::KIND_HEADER;
                        last_v          = 1'b1;
                        exp_next        = exp_reg + 1'b1;
                        hdr_idx_next    = '0;
                        magic_good_next = 1'b1;
                    end

                    if (kind_v == fhd_pkg::KIND_ERROR)
                    begin
                        err_next        = 1'b1;
                        in_payload_next = 1'b0;
                    end
                end
            end
        end

        push_word.item_kind      = kind_v;
        push_word.frame_type     = type_next;
        push_word.frame_sequence = seq_next;
        push_word.frame_length   = len_next;
        push_word.payload_byte   = byte_v;
        push_word.frame_last     = last_v;
        push_word.error_code     = (kind_v == fhd_pkg::KIND_ERROR) ? code_v : fhd_pkg::ERR_MAGIC;
    end

endmodule

FILE: rtl/fhd_queue.sv
// short result queue between the front end and the output stage
module fhd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fhd_pkg::item_t          push_word,
    input  logic                    pop,
    output fhd_pkg::item_t          head_word,
    output fhd_pkg::queue_status_t  status
);

    fhd_pkg::item_t entry_reg [fhd_pkg::QUEUE_DEPTH];

    logic [fhd_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fhd_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fhd_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign status.full  = (count_reg == fhd_pkg::QUEUE_CW'(fhd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_word    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/fhd_back.sv
// output stage: drains the queue into the registered result channel
module fhd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fhd_pkg::item_t          head_word,
    input  fhd_pkg::queue_status_t  q_status,
    output logic                    pop,
    input  logic                    item_stall,
    output logic                    item_valid,
    output fhd_pkg::item_t          item_word
);

    logic           valid_reg, valid_next;
    fhd_pkg::item_t word_reg;

    assign pop        = !q_status.empty && (!valid_reg || !item_stall);
    assign item_valid = valid_reg;
    assign item_word  = word_reg;

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!item_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= head_word;
        end
    end

endmodule

FILE: rtl/frame_header_deframer_top.sv
// frame header deframer top level
// one input word per cycle sustained, input stalls only while the result queue is full
// a result word passes through the queue entry and then the output register before it is shown
// header checks run in the cycle the last header byte is taken, all in parallel, the first failing one reported
// header bytes other than the last produce no result
// reset is asynchronous: parser, sequence, queue and output valid clear, registers take defaults
module frame_header_deframer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stream_valid,
    input  logic [7:0]                      stream_byte,
    output logic                            stream_stall,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fhd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            item_valid,
    input  logic                            item_stall,
    output logic [1:0]                      item_kind,
    output logic [15:0]                     frame_type,
    output logic [63:0]                     frame_sequence,
    output logic [31:0]                     frame_length,
    output logic [7:0]                      payload_byte,
    output logic                            frame_last,
    output logic [2:0]                      error_code
);

    fhd_pkg::queue_status_t q_status;
    fhd_pkg::item_t         push_word;
    fhd_pkg::item_t         head_word;
    fhd_pkg::item_t         item_word;
    logic                   push;
    logic                   pop;

    assign cfg_ready = 1'b1;

    fhd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_byte  (stream_byte),
        .stream_stall (stream_stall),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_status     (q_status),
        .push         (push),
        .push_word    (push_word)
    );

    fhd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .status    (q_status)
    );

    fhd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_word  (head_word),
        .q_status   (q_status),
        .pop        (pop),
        .item_stall (item_stall),
        .item_valid (item_valid),
        .item_word  (item_word)
    );

    assign item_kind      = item_word.item_kind;
    assign frame_type     = item_word.frame_type;
    assign frame_sequence = item_word.frame_sequence;
    assign frame_length   = item_word.frame_length;
    assign payload_byte   = item_word.payload_byte;
    assign frame_last     = item_word.frame_last;
    assign error_code     = item_word.error_code;

endmodule

FILE: rtl/fhd_checker.sv
// port-level checks for the frame header deframer, bound to the top level
`include "frame_header_deframer_top_defines.svh"

module fhd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [1:0]  item_kind,
    input logic [15:0] frame_type,
    input logic [63:0] frame_sequence,
    input logic [31:0] frame_length,
    input logic [7:0]  payload_byte,
    input logic        frame_last,
    input logic [2:0]  error_code
);

    `FHD_ASSERT_NEXT(a_stalled_word_holds, clk, rst_n, item_valid && item_stall, item_valid && $stable(item_kind) && $stable(frame_type) && $stable(frame_sequence) && $stable(frame_length) && $stable(payload_byte) && $stable(frame_last) && $stable(error_code), "stalled result word changed")

    `FHD_ASSERT_HOLDS(a_kind_legal, clk, rst_n, item_valid, item_kind == fhd_pkg::KIND_HEADER || item_kind == fhd_pkg::KIND_PAYLOAD || item_kind == fhd_pkg::KIND_ERROR, "illegal item kind")

    `FHD_ASSERT_HOLDS(a_error_word_shape, clk, rst_n, item_valid && item_kind == fhd_pkg::KIND_ERROR, !frame_last && payload_byte == 8'd0 && error_code <= fhd_pkg::ERR_EXHAUSTED, "malformed error word")

    `FHD_ASSERT_HOLDS(a_clean_word_shape, clk, rst_n, item_valid && item_kind != fhd_pkg::KIND_ERROR, error_code == fhd_pkg::ERR_MAGIC, "error code on a non-error word")

    `FHD_ASSERT_NEXT(a_silent_after_error, clk, rst_n, item_valid && !item_stall && item_kind == fhd_pkg::KIND_ERROR, !item_valid, "result after a latched error")

endmodule

bind frame_header_deframer_top fhd_checker u_fhd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item_kind      (item_kind),
    .frame_type     (frame_type),
    .frame_sequence (frame_sequence),
    .frame_length   (frame_length),
    .payload_byte   (payload_byte),
    .frame_last     (frame_last),
    .error_code     (error_code)
);
